@@ sv/ilbr_pkg.sv @@
package ilbr_pkg;

  localparam int RAMP_STEPS_DEF = 8;
  localparam int RAMP_MAX       = 8;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam logic [7:0] STEP_MS_RESET = 8'd50;

  localparam logic [2:0] FUNC_BACKLIGHT = 3'd0;
  localparam logic [2:0] FUNC_BUTTONS   = 3'd1;
  localparam logic [2:0] FUNC_ATTENTION = 3'd2;
  localparam logic [2:0] FUNC_NOTIFY    = 3'd3;
  localparam logic [2:0] FUNC_BATTERY   = 3'd4;

  localparam logic [1:0] SLOT_BUTTONS   = 2'd0;
  localparam logic [1:0] SLOT_ATTENTION = 2'd1;
  localparam logic [1:0] SLOT_NOTIFY    = 2'd2;
  localparam logic [1:0] SLOT_BATTERY   = 2'd3;

  localparam logic [1:0] TGT_BACKLIGHT = 2'd0;
  localparam logic [1:0] TGT_INDICATOR = 2'd1;
  localparam logic [1:0] TGT_NONE      = 2'd2;

  localparam logic ST_OK          = 1'b0;
  localparam logic ST_UNSUPPORTED = 1'b1;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] color;
    logic        flash_timed;
    logic [15:0] flash_on_ms;
    logic [15:0] flash_off_ms;
  } in_t;

  typedef struct packed {
    logic        status;
    logic [1:0]  target;
    logic [7:0]  level;
    logic        blink;
    logic [7:0]  step_ms;
    logic [15:0] pause_hi_ms;
    logic [15:0] pause_lo_ms;
    logic [2:0]  ramp_index;
    logic [6:0]  ramp_duty;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [23:0] rgb;
    logic        timed;
    logic [15:0] on_ms;
    logic [15:0] off_ms;
  } slot_t;

  typedef enum logic [1:0] {
    K_BACKLIGHT,
    K_UPDATE,
    K_UNSUP
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [1:0] slot;
    slot_t      s;
  } cmd_t;

  function automatic logic [7:0] luma(input logic [23:0] rgb);
    logic [15:0] sum;
    sum = 16'(rgb[23:16]) * 16'd77 + 16'(rgb[15:8]) * 16'd150 + 16'(rgb[7:0]) * 16'd29;
    return sum[15:8];
  endfunction

  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
    return t[15:8];
  endfunction

  function automatic logic [6:0] ramp_pct(input logic [2:0] i);
    logic [6:0] p;
    unique case (i)
      3'd0: p = 7'd0;
      3'd1: p = 7'd12;
      3'd2: p = 7'd25;
      3'd3: p = 7'd37;
      3'd4: p = 7'd50;
      3'd5: p = 7'd72;
      3'd6: p = 7'd85;
      3'd7: p = 7'd100;
      default: p = 7'd0;
    endcase
    return p;
  endfunction

endpackage

@@ sv/ilbr_chan_if.sv @@
interface ilbr_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

@@ sv/ilbr_front.sv @@
module ilbr_front (
  input  logic        clk,
  input  logic        rst_n,
  ilbr_chan_if.sink   in_ch,
  ilbr_chan_if.source cmd_ch
);

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_DIV, F_OUT} fstate_t;

  fstate_t           state_r, state_nxt;
  ilbr_pkg::cmd_t    cmd_r, cmd_nxt;
  logic [7:0]        alpha_r, alpha_nxt;
  logic [1:0]        ch_r, ch_nxt;
  logic [15:0]       prod_r, prod_nxt;
  logic [7:0]        alpha_in;

  assign in_ch.ready  = (state_r == F_IDLE);
  assign cmd_ch.valid = (state_r == F_OUT);
  assign cmd_ch.data  = cmd_r;
  assign alpha_in     = in_ch.data.color[31:24];

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    alpha_nxt = alpha_r;
    ch_nxt    = ch_r;
    prod_nxt  = prod_r;
    unique case (state_r)
      F_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt.s.rgb    = in_ch.data.color[23:0];
          cmd_nxt.s.timed  = in_ch.data.flash_timed;
          cmd_nxt.s.on_ms  = in_ch.data.flash_on_ms;
          cmd_nxt.s.off_ms = in_ch.data.flash_off_ms;
          cmd_nxt.kind     = ilbr_pkg::K_UPDATE;
          cmd_nxt.slot     = ilbr_pkg::SLOT_BUTTONS;
          alpha_nxt        = alpha_in;
          ch_nxt           = 2'd0;
          state_nxt        = F_OUT;
          unique case (in_ch.data.func)
            ilbr_pkg::FUNC_BACKLIGHT: cmd_nxt.kind = ilbr_pkg::K_BACKLIGHT;
            ilbr_pkg::FUNC_BUTTONS:   cmd_nxt.slot = ilbr_pkg::SLOT_BUTTONS;
            ilbr_pkg::FUNC_ATTENTION: cmd_nxt.slot = ilbr_pkg::SLOT_ATTENTION;
            ilbr_pkg::FUNC_NOTIFY: begin
              cmd_nxt.slot = ilbr_pkg::SLOT_NOTIFY;
              if (alpha_in != 8'd0 && alpha_in != ilbr_pkg::ALPHA_OPAQUE) begin
                state_nxt = F_MUL;
              end
            end
            ilbr_pkg::FUNC_BATTERY:   cmd_nxt.slot = ilbr_pkg::SLOT_BATTERY;
            default:                  cmd_nxt.kind = ilbr_pkg::K_UNSUP;
          endcase
        end
      end
      F_MUL: begin
        prod_nxt  = 16'(cmd_r.s.rgb[{ch_r, 3'b000} +: 8]) * 16'(alpha_r);
        state_nxt = F_DIV;
      end
      F_DIV: begin
        cmd_nxt.s.rgb[{ch_r, 3'b000} +: 8] = ilbr_pkg::div255(prod_r);
        if (ch_r == 2'd2) begin
          state_nxt = F_OUT;
        end else begin
          ch_nxt    = ch_r + 2'd1;
          state_nxt = F_MUL;
        end
      end
      F_OUT: begin
        if (cmd_ch.ready) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    alpha_r <= alpha_nxt;
    ch_r    <= ch_nxt;
    prod_r  <= prod_nxt;
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ sv/ilbr_fifo.sv @@
module ilbr_fifo #(
  parameter int DEPTH = ilbr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  ilbr_chan_if.sink   push_ch,
  ilbr_chan_if.source pop_ch
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ilbr_pkg::cmd_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign push_ch.ready = (cnt_r != CNT_W'(DEPTH));
  assign pop_ch.valid  = (cnt_r != '0);
  assign pop_ch.data   = mem_r[rd_ptr_r];
  assign do_push       = push_ch.valid && push_ch.ready;
  assign do_pop        = pop_ch.valid && pop_ch.ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_ch.data;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

@@ sv/ilbr_back.sv @@
module ilbr_back #(
  parameter int RAMP_STEPS = ilbr_pkg::RAMP_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  ilbr_chan_if.sink   cmd_ch,
  ilbr_chan_if.sink   cfg_ch,
  ilbr_chan_if.source out_ch
);

  localparam int TWO_R  = 2 * RAMP_STEPS;
  localparam int RAMP_N = (RAMP_STEPS < ilbr_pkg::RAMP_MAX) ? RAMP_STEPS : ilbr_pkg::RAMP_MAX;
  localparam int DIV_SH = 21;
  localparam int DIV_M  = ((1 << DIV_SH) + TWO_R - 1) / TWO_R;

  typedef enum logic [2:0] {B_IDLE, B_SEL, B_EVAL, B_DIV, B_RAMP, B_DUTY} bstate_t;

  bstate_t         state_r, state_nxt;
  ilbr_pkg::slot_t slots_r [4];
  ilbr_pkg::slot_t slots_nxt [4];
  ilbr_pkg::slot_t shown_r, shown_nxt;
  ilbr_pkg::out_t  out_r, out_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      dstep_r;
  logic [7:0]      level_r, level_nxt;
  logic [7:0]      step_r, step_nxt;
  logic [15:0]     phi_r, phi_nxt;
  logic [7:0]      quo_r, quo_nxt;
  logic [2:0]      idx_r, idx_nxt;
  logic [14:0]     prod_r, prod_nxt;

  logic            out_free;
  logic            blink;
  logic [7:0]      eff_step;
  logic [15:0]     span;
  logic            ramp_last;

  assign out_free     = !out_valid_r || out_ch.ready;
  assign cmd_ch.ready = (state_r == B_IDLE) && out_free;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  assign blink     = shown_r.timed && (shown_r.on_ms != 16'd0) && (shown_r.off_ms != 16'd0);
  assign eff_step  = (dstep_r == 8'd0) ? 8'd1 : dstep_r;
  assign span      = 16'(eff_step) * 16'(TWO_R);
  assign ramp_last = (idx_r == 3'(RAMP_N - 1));

  always_comb begin
    state_nxt     = state_r;
    slots_nxt     = slots_r;
    shown_nxt     = shown_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    level_nxt     = level_r;
    step_nxt      = step_r;
    phi_nxt       = phi_r;
    quo_nxt       = quo_r;
    idx_nxt       = idx_r;
    prod_nxt      = prod_r;
    unique case (state_r)
      B_IDLE: begin
        if (cmd_ch.valid && out_free) begin
          unique case (cmd_ch.data.kind)
            ilbr_pkg::K_BACKLIGHT: begin
              out_nxt        = '0;
              out_nxt.status = ilbr_pkg::ST_OK;
              out_nxt.target = ilbr_pkg::TGT_BACKLIGHT;
              out_nxt.level  = ilbr_pkg::luma(cmd_ch.data.s.rgb);
              out_nxt.last   = 1'b1;
              out_valid_nxt  = 1'b1;
            end
            ilbr_pkg::K_UPDATE: begin
              slots_nxt[cmd_ch.data.slot] = cmd_ch.data.s;
              state_nxt = B_SEL;
            end
            default: begin
              out_nxt        = '0;
              out_nxt.status = ilbr_pkg::ST_UNSUPPORTED;
              out_nxt.target = ilbr_pkg::TGT_NONE;
              out_nxt.last   = 1'b1;
              out_valid_nxt  = 1'b1;
            end
          endcase
        end
      end
      B_SEL: begin
        if (slots_r[ilbr_pkg::SLOT_NOTIFY].rgb != 24'd0) begin
          shown_nxt = slots_r[ilbr_pkg::SLOT_NOTIFY];
        end else if (slots_r[ilbr_pkg::SLOT_ATTENTION].rgb != 24'd0) begin
          shown_nxt = slots_r[ilbr_pkg::SLOT_ATTENTION];
        end else if (slots_r[ilbr_pkg::SLOT_BUTTONS].rgb != 24'd0) begin
          shown_nxt = slots_r[ilbr_pkg::SLOT_BUTTONS];
        end else begin
          shown_nxt = slots_r[ilbr_pkg::SLOT_BATTERY];
        end
        state_nxt = B_EVAL;
      end
      B_EVAL: begin
        level_nxt = ilbr_pkg::luma(shown_r.rgb);
        if (!blink) begin
          if (out_free) begin
            out_nxt        = '0;
            out_nxt.status = ilbr_pkg::ST_OK;
            out_nxt.target = ilbr_pkg::TGT_INDICATOR;
            out_nxt.level  = level_nxt;
            out_nxt.last   = 1'b1;
            out_valid_nxt  = 1'b1;
            state_nxt      = B_IDLE;
          end
        end else if (shown_r.on_ms >= span) begin
          step_nxt  = eff_step;
          phi_nxt   = shown_r.on_ms - span;
          idx_nxt   = 3'd0;
          state_nxt = B_RAMP;
        end else begin
          quo_nxt   = 8'((40'(shown_r.on_ms) * 40'(DIV_M)) >> DIV_SH);
          state_nxt = B_DIV;
        end
      end
      B_DIV: begin
        step_nxt  = (quo_r == 8'd0) ? 8'd1 : quo_r;
        phi_nxt   = 16'd0;
        idx_nxt   = 3'd0;
        state_nxt = B_RAMP;
      end
      B_RAMP: begin
        prod_nxt  = 15'(ilbr_pkg::ramp_pct(idx_r)) * 15'(level_r);
        state_nxt = B_DUTY;
      end
      B_DUTY: begin
        if (out_free) begin
          out_nxt.status      = ilbr_pkg::ST_OK;
          out_nxt.target      = ilbr_pkg::TGT_INDICATOR;
          out_nxt.level       = level_r;
          out_nxt.blink       = 1'b1;
          out_nxt.step_ms     = step_r;
          out_nxt.pause_hi_ms = phi_r;
          out_nxt.pause_lo_ms = shown_r.off_ms;
          out_nxt.ramp_index  = idx_r;
          out_nxt.ramp_duty   = 7'(ilbr_pkg::div255(16'(prod_r)));
          out_nxt.last        = ramp_last;
          out_valid_nxt       = 1'b1;
          if (ramp_last) begin
            state_nxt = B_IDLE;
          end else begin
            idx_nxt   = idx_r + 3'd1;
            state_nxt = B_RAMP;
          end
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    shown_r <= shown_nxt;
    out_r   <= out_nxt;
    level_r <= level_nxt;
    step_r  <= step_nxt;
    phi_r   <= phi_nxt;
    quo_r   <= quo_nxt;
    idx_r   <= idx_nxt;
    prod_r  <= prod_nxt;
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      slots_r     <= '{default: '0};
      dstep_r     <= ilbr_pkg::STEP_MS_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      slots_r     <= slots_nxt;
      if (cfg_ch.valid) begin
        dstep_r <= cfg_ch.data;
      end
    end
  end

  a_ramp_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.blink && out_ch.data.last
      |-> out_ch.data.ramp_index == 3'(RAMP_N - 1))
    else $error("ramp ended at wrong index");

  a_steady_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.data.blink
      |-> out_ch.data.last && out_ch.data.ramp_duty == 7'd0 && out_ch.data.step_ms == 8'd0)
    else $error("steady transaction malformed");

  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.data.ramp_duty <= 7'd100)
    else $error("duty above full scale");

  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_DIV |=> state_r == B_RAMP)
    else $error("step divider did not finish");

  a_blink_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.blink |-> out_ch.data.step_ms != 8'd0)
    else $error("blink ramp with zero step");

endmodule

@@ sv/indicator_led_arbiter_blink_ramp_top.sv @@
// A backlight or unsupported request gives one result; a slot update goes through slot select
// and evaluation to a steady result or a blink ramp, with a reciprocal multiply for the step
// time first when the on time is shorter than a full ramp. Blink entries go out one at a time
// through the shared duty multiplier and /255, and wait while out_ch is held; the front scales
// notification alpha per colour channel; a 2-entry queue decouples the halves.
// Reset: synchronous rst_n clears all four slots to unlit, the step register to 50, the queue.
module indicator_led_arbiter_blink_ramp_top #(
  parameter int RAMP_STEPS  = ilbr_pkg::RAMP_STEPS_DEF,
  parameter int QUEUE_DEPTH = ilbr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  ilbr_chan_if.sink   in_ch,
  ilbr_chan_if.sink   cfg_ch,
  ilbr_chan_if.source out_ch
);

  ilbr_chan_if #(.T(ilbr_pkg::cmd_t)) push_if ();
  ilbr_chan_if #(.T(ilbr_pkg::cmd_t)) pop_if ();

  ilbr_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cmd_ch (push_if)
  );

  ilbr_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_ch (push_if),
    .pop_ch  (pop_if)
  );

  ilbr_back #(
    .RAMP_STEPS (RAMP_STEPS)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd_ch (pop_if),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch)
  );

endmodule
